// File: rtl/jrq_pkg.sv
package jrq_pkg;

  // request opcodes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DUMP   = 1'b1;

  // order_mode codes; the unused code behaves as FIFO
  localparam logic [1:0] MODE_FIFO = 2'd0;
  localparam logic [1:0] MODE_PRIO = 2'd1;
  localparam logic [1:0] MODE_SJF  = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic insert;      // place the request's job into the queue
    logic rotate;      // shift the occupied region down by one, head wraps to tail
    logic clr_cnt;     // restart the dump counter
    logic load_out;    // capture a result into the output register
    logic out_entry;   // result carries the head entry
    logic out_reject;  // result flags a refused insert
    logic out_last;    // result closes the request
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
    logic last_entry;  // dump counter points at the final occupied slot
    logic out_free;    // output register can take a result this cycle
  } status_t;

endpackage

// File: rtl/jrq_ctrl.sv
module jrq_ctrl
  import jrq_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    op_i,
  output logic    in_stall_o,
  input  status_t sts_i,
  output cmd_t    cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DUMP = 1'b1;

  logic state_q, state_d;
  logic accept;

  assign accept = (state_q == ST_IDLE) && in_valid_i && sts_i.out_free;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = !sts_i.out_free;
        if (accept) begin
          if (op_i == OP_INSERT) begin
            cmd_o.load_out   = 1'b1;
            cmd_o.out_last   = 1'b1;
            cmd_o.out_reject = sts_i.full;
            cmd_o.insert     = !sts_i.full;
          end else if (sts_i.empty) begin
            cmd_o.load_out = 1'b1;
            cmd_o.out_last = 1'b1;
          end else begin
            cmd_o.clr_cnt = 1'b1;
            state_d       = ST_DUMP;
          end
        end
      end
      ST_DUMP: begin
        if (sts_i.out_free) begin
          cmd_o.load_out  = 1'b1;
          cmd_o.out_entry = 1'b1;
          cmd_o.out_last  = sts_i.last_entry;
          cmd_o.rotate    = 1'b1;
          if (sts_i.last_entry) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/jrq_dpath.sv
module jrq_dpath
  import jrq_pkg::*;
#(
  parameter int unsigned DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  input  logic [7:0]  job_id_i,
  input  logic [7:0]  job_priority_i,
  input  logic [15:0] job_length_i,
  input  logic        out_stall_i,
  output logic        out_valid_o,
  output logic        entry_valid_o,
  output logic [7:0]  out_job_id_o,
  output logic [7:0]  out_priority_o,
  output logic [15:0] out_length_o,
  output logic        full_reject_o,
  output logic        last_o,
  input  cmd_t        cmd_i,
  output status_t     sts_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = $clog2(DEPTH);

  logic [1:0]  mode_q;
  logic [CW-1:0] occ_q;
  logic [CW-1:0] occ_m1;
  logic [IW-1:0] cnt_q;

  logic [7:0]  id_q   [DEPTH];
  logic [7:0]  prio_q [DEPTH];
  logic [15:0] len_q  [DEPTH];

  logic [DEPTH-1:0] hit;

  logic        out_valid_q, entry_q, reject_q, last_q;
  logic [7:0]  oid_q, oprio_q;
  logic [15:0] olen_q;

  assign occ_m1 = occ_q - CW'(1);

  assign sts_o.full       = (occ_q == CW'(DEPTH));
  assign sts_o.empty      = (occ_q == '0);
  assign sts_o.last_entry = (CW'(cnt_q) == occ_m1);
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  // per-slot compare and local shift
  for (genvar i = 0; i < DEPTH; i++) begin : g_slot
    localparam logic [DEPTH-1:0] LowMask = {DEPTH{1'b1}} >> (DEPTH - i);
    logic        in_use, ahead, take_new, shift_up;
    logic [7:0]  up_id, up_prio, dn_id, dn_prio;
    logic [15:0] up_len, dn_len;

    assign in_use = (CW'(i) < occ_q);
    assign hit[i] = in_use &&
                    (((mode_q == MODE_PRIO) && (prio_q[i] <= job_priority_i)) ||
                     ((mode_q == MODE_SJF) && (len_q[i] >= job_length_i)));
    assign ahead    = |(hit & LowMask);
    assign take_new = !ahead && (hit[i] || (CW'(i) == occ_q));
    assign shift_up = ahead && (CW'(i) <= occ_q);

    if (i == 0) begin : g_first
      assign up_id   = id_q[0];
      assign up_prio = prio_q[0];
      assign up_len  = len_q[0];
    end else begin : g_mid
      assign up_id   = id_q[i-1];
      assign up_prio = prio_q[i-1];
      assign up_len  = len_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign dn_id   = id_q[i];
      assign dn_prio = prio_q[i];
      assign dn_len  = len_q[i];
    end else begin : g_body
      assign dn_id   = id_q[i+1];
      assign dn_prio = prio_q[i+1];
      assign dn_len  = len_q[i+1];
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.insert) begin
        if (take_new) begin
          id_q[i]   <= job_id_i;
          prio_q[i] <= job_priority_i;
          len_q[i]  <= job_length_i;
        end else if (shift_up) begin
          id_q[i]   <= up_id;
          prio_q[i] <= up_prio;
          len_q[i]  <= up_len;
        end
      end else if (cmd_i.rotate) begin
        if (CW'(i) == occ_m1) begin
          id_q[i]   <= id_q[0];
          prio_q[i] <= prio_q[0];
          len_q[i]  <= len_q[0];
        end else if (CW'(i) < occ_m1) begin
          id_q[i]   <= dn_id;
          prio_q[i] <= dn_prio;
          len_q[i]  <= dn_len;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_FIFO;
      occ_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (cmd_i.insert) begin
        occ_q <= occ_q + CW'(1);
      end
      if (cmd_i.clr_cnt) begin
        cnt_q <= '0;
      end else if (cmd_i.rotate) begin
        cnt_q <= cnt_q + IW'(1);
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      entry_q  <= cmd_i.out_entry;
      reject_q <= cmd_i.out_reject;
      last_q   <= cmd_i.out_last;
      oid_q    <= cmd_i.out_entry ? id_q[0]   : 8'd0;
      oprio_q  <= cmd_i.out_entry ? prio_q[0] : 8'd0;
      olen_q   <= cmd_i.out_entry ? len_q[0]  : 16'd0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign entry_valid_o  = entry_q;
  assign out_job_id_o   = oid_q;
  assign out_priority_o = oprio_q;
  assign out_length_o   = olen_q;
  assign full_reject_o  = reject_q;
  assign last_o         = last_q;

endmodule

// File: rtl/job_ready_queue_sorted_insert.sv
// Insert: one result, registered in the cycle after the request is taken; inserts
//   sustain one request per cycle while the result side keeps up.
// Dump: entries pass the dump state, then the output register, one per cycle while
//   the result side keeps up; the next request waits for the last entry (empty
//   queue: one result, as insert). Reset clears occupancy, order_mode and the
//   output valid; slot storage is left as is and only read below occupancy.
module job_ready_queue_sorted_insert
  import jrq_pkg::*;
#(
  parameter int unsigned DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [7:0]  job_id_i,
  input  logic [7:0]  job_priority_i,
  input  logic [15:0] job_length_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        entry_valid_o,
  output logic [7:0]  out_job_id_o,
  output logic [7:0]  out_priority_o,
  output logic [15:0] out_length_o,
  output logic        full_reject_o,
  output logic        last_o
);

  // The queue is a row of slots kept in order. On insert every occupied slot
  // compares its key with the new job at once; the first hit (or the tail when
  // none hits, always so in FIFO mode) takes the new job and the slots after it
  // shift up by one. A dump emits slot 0 and rotates the occupied region, so after
  // occupancy steps the queue is back in its original order.
  cmd_t    cmd;
  status_t sts;

  jrq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  jrq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .job_id_i       (job_id_i),
    .job_priority_i (job_priority_i),
    .job_length_i   (job_length_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .entry_valid_o  (entry_valid_o),
    .out_job_id_o   (out_job_id_o),
    .out_priority_o (out_priority_o),
    .out_length_o   (out_length_o),
    .full_reject_o  (full_reject_o),
    .last_o         (last_o),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

  // a refused insert is a single closing result without an entry
  a_reject_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && full_reject_o |-> last_o && !entry_valid_o)
    else $error("reject result malformed");

  // no request is taken while a dump streams
  a_dump_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rotate |-> in_stall_o)
    else $error("request accepted during dump");

  // never write into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.insert |-> !sts.full)
    else $error("insert into full queue");

  // each dump step presents an entry on the next cycle
  a_dump_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rotate |=> out_valid_o && entry_valid_o)
    else $error("dump step lost its result");

endmodule

// File: sim/tb_job_ready_queue_sorted_insert.sv
`timescale 1ns / 1ps

module tb_job_ready_queue_sorted_insert;
  import jrq_pkg::*;

  localparam int unsigned DEPTH = 32;
  localparam int ITEM_TARGET = 310;
  localparam int LONG_HOLD = 150;      // cycles the result side holds off once
  localparam int SETTLE_CYCLES = 4;    // quiet cycles before a mode write
  localparam int DRAIN_CYCLES = 40;    // quiet cycles at the end
  localparam int TIMEOUT_NS = 4_000_000;

  // order_mode has no named code for its spare value; it behaves as FIFO
  localparam logic [1:0] MODE_SPARE = 2'd3;

  // one result as seen on the output ports
  typedef struct packed {
    logic        entry_valid;
    logic [7:0]  job_id;
    logic [7:0]  prio;
    logic [15:0] len;
    logic        reject;
    logic        last;
  } reply_t;

  // results that can be read straight off the spec
  localparam reply_t REPLY_ACK    = {1'b0, 8'h00, 8'h00, 16'h0000, 1'b0, 1'b1};
  localparam reply_t REPLY_EMPTY  = {1'b0, 8'h00, 8'h00, 16'h0000, 1'b0, 1'b1};
  localparam reply_t REPLY_REJECT = {1'b0, 8'h00, 8'h00, 16'h0000, 1'b1, 1'b1};

  // directed rows: either a request or a mode write
  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [1:0]  mode;
    logic        op;
    logic [7:0]  id;
    logic [7:0]  prio;
    logic [15:0] len;
    logic        typed;   // want holds the expected result, skip the shadow queue
    reply_t      want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_wdata = MODE_FIFO;
  logic        in_valid = 1'b0;
  logic        req_op = OP_INSERT;
  logic [7:0]  req_id = '0;
  logic [7:0]  req_prio = '0;
  logic [15:0] req_len = '0;
  logic        out_stall = 1'b0;

  logic        in_stall_o;
  logic        out_valid_o;
  logic        entry_valid_o;
  logic [7:0]  out_job_id_o;
  logic [7:0]  out_priority_o;
  logic [15:0] out_length_o;
  logic        full_reject_o;
  logic        last_o;

  // shadow copy of the ready queue and its mode
  logic [7:0]  shadow_id   [DEPTH];
  logic [7:0]  shadow_prio [DEPTH];
  logic [15:0] shadow_len  [DEPTH];
  int          shadow_count = 0;
  logic [1:0]  shadow_mode = MODE_FIFO;

  reply_t      shadow_out[$];       // results of the last request applied
  reply_t      awaited_replies[$];  // results owed by the block, oldest first
  stim_row_t   stim_rows[$];

  int          mismatch_cnt = 0;
  int          sent_cnt = 0;
  bit          hold_req = 1'b0;     // asks the result side for one long hold-off

  job_ready_queue_sorted_insert #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .op_i          (req_op),
    .job_id_i      (req_id),
    .job_priority_i(req_prio),
    .job_length_i  (req_len),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .entry_valid_o (entry_valid_o),
    .out_job_id_o  (out_job_id_o),
    .out_priority_o(out_priority_o),
    .out_length_o  (out_length_o),
    .full_reject_o (full_reject_o),
    .last_o        (last_o)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow queue: applies one request and leaves its results in shadow_out.
  // ---------------------------------------------------------------------------
  function automatic reply_t make_reply(logic ev, logic [7:0] id, logic [7:0] prio,
                                        logic [15:0] len, logic rej, logic lst);
    return {ev, id, prio, len, rej, lst};
  endfunction

  function automatic void apply_to_shadow_queue(logic op, logic [7:0] id, logic [7:0] prio,
                                                logic [15:0] len);
    int slot;
    shadow_out.delete();
    if (op == OP_DUMP) begin
      // dump leaves the queue as is; an empty queue still owes one closing result
      if (shadow_count == 0)
        shadow_out.push_back(make_reply(1'b0, 8'h00, 8'h00, 16'h0000, 1'b0, 1'b1));
      for (int i = 0; i < shadow_count; i++)
        shadow_out.push_back(make_reply(1'b1, shadow_id[i], shadow_prio[i], shadow_len[i],
                                        1'b0, (i == shadow_count - 1)));
    end else if (shadow_count >= DEPTH) begin
      shadow_out.push_back(make_reply(1'b0, 8'h00, 8'h00, 16'h0000, 1'b1, 1'b1));
    end else begin
      // scan from the tail down so the lowest hit wins; FIFO and spare mode append
      slot = shadow_count;
      for (int i = shadow_count - 1; i >= 0; i--) begin
        if (shadow_mode == MODE_PRIO && shadow_prio[i] <= prio) slot = i;
        if (shadow_mode == MODE_SJF && shadow_len[i] >= len) slot = i;
      end
      for (int i = shadow_count; i > slot; i--) begin
        shadow_id[i]   = shadow_id[i - 1];
        shadow_prio[i] = shadow_prio[i - 1];
        shadow_len[i]  = shadow_len[i - 1];
      end
      shadow_id[slot]   = id;
      shadow_prio[slot] = prio;
      shadow_len[slot]  = len;
      shadow_count++;
      shadow_out.push_back(make_reply(1'b0, 8'h00, 8'h00, 16'h0000, 1'b0, 1'b1));
    end
  endfunction

  // mostly back-to-back, sometimes short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 30);
  endfunction

  // key values lean toward ties and extremes so ordering corners show up often
  function automatic logic [15:0] pick_key(int width);
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(0, 3));
      1:       return $urandom_range(0, 1) ? 16'((1 << width) - 1) : 16'd0;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic log_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatch_cnt++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      log_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
  endtask

  // ---------------------------------------------------------------------------
  // Request side. Called at a rising edge; returns at the edge that took the
  // request, with valid still high so a back-to-back request can follow.
  // ---------------------------------------------------------------------------
  task automatic send_job_req(input logic op, input logic [7:0] id, input logic [7:0] prio,
                              input logic [15:0] len, input logic typed, input reply_t want,
                              input bit no_gap);
    int gap;
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_op   <= op;
    req_id   <= id;
    req_prio <= prio;
    req_len  <= len;
    do @(posedge clk); while (in_stall_o);
    apply_to_shadow_queue(op, id, prio, len);
    if (typed) awaited_replies.push_back(want);
    else foreach (shadow_out[k]) awaited_replies.push_back(shadow_out[k]);
    sent_cnt++;
  endtask

  task automatic send_random_req(input bit no_gap);
    logic op;
    op = ($urandom_range(0, 99) < 60) ? OP_INSERT : OP_DUMP;
    send_job_req(op, 8'($urandom), 8'(pick_key(8)), pick_key(16), 1'b0, REPLY_ACK, no_gap);
  endtask

  // mode writes only land on an idle block: nothing owed, then SETTLE_CYCLES quiet cycles
  task automatic write_mode(input logic [1:0] mode);
    in_valid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_mode = mode;
  endtask

  function automatic void add_req(logic op, logic [7:0] id, logic [7:0] prio,
                                  logic [15:0] len, logic typed, reply_t want);
    stim_rows.push_back({ROW_REQ, MODE_FIFO, op, id, prio, len, typed, want});
  endfunction

  function automatic void add_cfg(logic [1:0] mode);
    stim_rows.push_back({ROW_CFG, mode, OP_INSERT, 8'h00, 8'h00, 16'h0000, 1'b0, REPLY_ACK});
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus: directed table, then random phases with a mode write between them.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    bit burst;
    int n;
    int phase;

    // dump after reset sees an empty queue
    add_req(OP_DUMP,   8'h00, 8'h00, 16'h0000, 1'b1, REPLY_EMPTY);
    // FIFO append with all-zero and all-one fields
    add_req(OP_INSERT, 8'h00, 8'h00, 16'h0000, 1'b1, REPLY_ACK);
    add_req(OP_INSERT, 8'hFF, 8'hFF, 16'hFFFF, 1'b1, REPLY_ACK);
    add_req(OP_INSERT, 8'h5A, 8'h80, 16'h1234, 1'b1, REPLY_ACK);
    add_req(OP_DUMP,   8'h00, 8'h00, 16'h0000, 1'b0, REPLY_ACK);
    // priority mode over FIFO-ordered contents; newcomers lead their ties
    add_cfg(MODE_PRIO);
    add_req(OP_INSERT, 8'h11, 8'h80, 16'h0001, 1'b1, REPLY_ACK);
    add_req(OP_INSERT, 8'h12, 8'hFF, 16'h8000, 1'b1, REPLY_ACK);
    add_req(OP_INSERT, 8'h13, 8'h00, 16'hFFFF, 1'b1, REPLY_ACK);
    add_req(OP_DUMP,   8'h00, 8'h00, 16'h0000, 1'b0, REPLY_ACK);
    // shortest first, zero and max lengths plus a length tie
    add_cfg(MODE_SJF);
    add_req(OP_INSERT, 8'h21, 8'h40, 16'h0000, 1'b1, REPLY_ACK);
    add_req(OP_INSERT, 8'h22, 8'h40, 16'hFFFF, 1'b1, REPLY_ACK);
    add_req(OP_INSERT, 8'h23, 8'h40, 16'h1234, 1'b1, REPLY_ACK);
    add_req(OP_DUMP,   8'h00, 8'h00, 16'h0000, 1'b0, REPLY_ACK);
    // spare mode code appends like FIFO
    add_cfg(MODE_SPARE);
    add_req(OP_INSERT, 8'hA5, 8'h7F, 16'h7FFF, 1'b1, REPLY_ACK);
    add_req(OP_DUMP,   8'h00, 8'h00, 16'h0000, 1'b0, REPLY_ACK);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_CFG)
        write_mode(stim_rows[i].mode);
      else
        send_job_req(stim_rows[i].op, stim_rows[i].id, stim_rows[i].prio, stim_rows[i].len,
                     stim_rows[i].typed, stim_rows[i].want, 1'b0);
    end

    // Random phases. The queue never drains, so it fills within the first
    // few phases; the rest exercises refused inserts and full dumps.
    phase = 0;
    while (sent_cnt < ITEM_TARGET) begin
      write_mode(2'($urandom_range(0, 3)));
      burst = ($urandom_range(0, 3) == 0);
      n = $urandom_range(4, 16);
      if (phase == 3) begin
        // result side stalls for a long stretch while requests keep coming
        hold_req = 1'b1;
        burst = 1'b1;
        n = 24;
      end
      repeat (n) send_random_req(burst);
      phase++;
    end

    in_valid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0)
      $display("job_ready_queue_sorted_insert test passed");
    else
      $display("job_ready_queue_sorted_insert test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts, plus one long hold-off on request.
  // ---------------------------------------------------------------------------
  initial begin : result_side
    int n;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      n = pick_gap();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6))
        @(posedge clk);
    end
  end

  // every taken result is matched against the oldest owed one
  always @(posedge clk) begin : result_check
    reply_t want;
    if (rst_n && out_valid_o && !out_stall) begin
      if (awaited_replies.size() == 0) begin
        log_mismatch($sformatf("result with nothing owed: id 0x%0h last %0b",
                               out_job_id_o, last_o));
      end else begin
        want = awaited_replies.pop_front();
        check_field("entry_valid", 16'(entry_valid_o), 16'(want.entry_valid));
        check_field("out_job_id", 16'(out_job_id_o), 16'(want.job_id));
        check_field("out_priority", 16'(out_priority_o), 16'(want.prio));
        check_field("out_length", out_length_o, want.len);
        check_field("full_reject", 16'(full_reject_o), 16'(want.reject));
        check_field("last", 16'(last_o), 16'(want.last));
      end
    end
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("job_ready_queue_sorted_insert test failed");
    $finish;
  end

endmodule

// File: files.f
rtl/jrq_pkg.sv
rtl/jrq_ctrl.sv
rtl/jrq_dpath.sv
rtl/job_ready_queue_sorted_insert.sv
sim/tb_job_ready_queue_sorted_insert.sv
